/* rtl/tams_pkg.sv */
// Shared types, widths and codes for the activity minute statistics block.
package tams_pkg;

  localparam int CENTER_W   = 12;
  localparam int RSQ_W      = 25;
  localparam int SCALE_W    = 16;
  localparam int THR_W      = 19;
  localparam int CNT_W      = 16;
  localparam int STEP_W     = 17;
  localparam int WSUM_W     = 19;
  localparam int PATH_W     = 33;
  localparam int SPEED_W    = 35;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [SCALE_W-1:0] SCALE_RST = 16'hFFFF;
  localparam logic [CNT_W-1:0]   FPM_RST   = 16'd1800;

  localparam logic [2:0] SQ_ROOT_GO = 3'd3;
  localparam logic [2:0] SQ_LAST    = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X      = 3'd0,
    CFG_CENTER_Y      = 3'd1,
    CFG_INNER_RSQ     = 3'd2,
    CFG_DIST_SCALE    = 3'd3,
    CFG_ACT_THRESHOLD = 3'd4,
    CFG_FRAMES_PER_MIN = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_SCALE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic       in_ready;
    logic       sq_en;
    logic [2:0] sq_idx;
    logic       sqrt_start;
    logic       scale_en;
    logic       finish;
  } ctrl_t;

  typedef struct packed {
    logic [STEP_W-1:0]  step_length;
    logic [WSUM_W-1:0]  window_sum;
    logic               window_full;
    logic               is_active;
    logic               is_shift;
    logic               is_inner;
    logic               minute_done;
    logic [PATH_W-1:0]  minute_path;
    logic [SPEED_W-1:0] minute_active_speed_sum;
    logic [CNT_W-1:0]   minute_active_frames;
    logic [CNT_W-1:0]   minute_shifts;
    logic [CNT_W-1:0]   minute_inner_frames;
  } res_t;

endpackage

/* rtl/tams_if.sv */
// Handshake channel interfaces: position input, result output, register write.
interface tams_in_if #(
  parameter int COORD_BITS = 12
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic                  end_of_track;

  modport source (output valid, output pos_x, output pos_y, output end_of_track,
                  input ready);
  modport sink   (input valid, input pos_x, input pos_y, input end_of_track,
                  output ready);
endinterface

interface tams_out_if import tams_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STEP_W-1:0]  step_length;
  logic [WSUM_W-1:0]  window_sum;
  logic               window_full;
  logic               is_active;
  logic               is_shift;
  logic               is_inner;
  logic               minute_done;
  logic [PATH_W-1:0]  minute_path;
  logic [SPEED_W-1:0] minute_active_speed_sum;
  logic [CNT_W-1:0]   minute_active_frames;
  logic [CNT_W-1:0]   minute_shifts;
  logic [CNT_W-1:0]   minute_inner_frames;

  modport source (output valid, output step_length, output window_sum,
                  output window_full, output is_active, output is_shift,
                  output is_inner, output minute_done, output minute_path,
                  output minute_active_speed_sum, output minute_active_frames,
                  output minute_shifts, output minute_inner_frames, input ready);
  modport sink   (input valid, input step_length, input window_sum,
                  input window_full, input is_active, input is_shift,
                  input is_inner, input minute_done, input minute_path,
                  input minute_active_speed_sum, input minute_active_frames,
                  input minute_shifts, input minute_inner_frames, output ready);
endinterface

interface tams_cfg_if import tams_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/tams_sqrt.sv */
// Bit-pair restoring integer square root, one result bit per cycle.
module tams_sqrt #(
  parameter int RW = 17
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [2*RW-1:0] rad_i,
  output logic            busy_o,
  output logic [RW-1:0]   root_o
);

  localparam int CW = (RW > 1) ? $clog2(RW) : 1;

  logic [2*RW-1:0] rad_q;
  logic [RW-1:0]   rem_q;
  logic [RW-1:0]   root_q;
  logic [CW-1:0]   cnt_q;
  logic            busy_q;

  logic [RW+1:0] rem_s;
  logic [RW+1:0] trial;
  logic [RW+1:0] diff;
  logic          take;

  assign rem_s = {rem_q, rad_q[2*RW-1 -: 2]};
  assign trial = {root_q, 2'b01};
  assign take  = rem_s >= trial;
  assign diff  = rem_s - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(RW - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[2*RW-3:0], 2'b00};
      rem_q  <= take ? diff[RW-1:0] : rem_s[RW-1:0];
      root_q <= {root_q[RW-2:0], take};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

/* rtl/tams_ctrl.sv */
// Sequencer: accept, square phases, root iterations, scaling, result load.
module tams_ctrl import tams_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_fire_i,
  input  logic  sqrt_busy_i,
  input  logic  out_free_i,
  output ctrl_t ctrl_o
);

  state_e     state_q, state_d;
  logic [2:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire_i) begin
          state_d = ST_SQUARE;
          cnt_d   = '0;
        end
      end
      ST_SQUARE: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == SQ_LAST) begin
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (!sqrt_busy_i) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl_o            = '0;
    ctrl_o.sq_idx     = cnt_q;
    ctrl_o.in_ready   = (state_q == ST_IDLE);
    ctrl_o.sq_en      = (state_q == ST_SQUARE);
    ctrl_o.sqrt_start = (state_q == ST_SQUARE) && (cnt_q == SQ_ROOT_GO);
    ctrl_o.scale_en   = (state_q == ST_SCALE);
    ctrl_o.finish     = (state_q == ST_FINISH) && out_free_i;
  end

endmodule

/* rtl/track_activity_minute_stats_top.sv */
// Activity minute statistics: step length, window activity, zone and minute totals.
//
//   channel  dir  handshake          payload
//   in_i     in   valid / ready      pos_x, pos_y, end_of_track
//   out_o    out  valid / ready      step and window flags, minute totals
//   cfg_i    in   valid / ready (=1) index, data
//
// A new item is accepted only after the previous one is loaded into the output
// register; the bit-pair square root loop yields one result bit per cycle.
// Squares and scaling share one multiplier.
// Reset clears all running state and loads register defaults.
// A stalled output holds one result; the next item is accepted meanwhile and
// waits in its last step until the output register frees.
module track_activity_minute_stats_top import tams_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int WINDOW_LEN = 5,
  parameter int FRAC_BITS  = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tams_in_if.sink      in_i,
  tams_out_if.source   out_o,
  tams_cfg_if.sink     cfg_i
);

  localparam int HIST_LEN = WINDOW_LEN - 1;
  localparam int FW       = $clog2(HIST_LEN + 1);
  localparam int SW       = STEP_W + $clog2(WINDOW_LEN);
  localparam int CMP_W    = (SW > THR_W) ? SW : THR_W;
  localparam int DW       = (COORD_BITS > CENTER_W) ? COORD_BITS : CENTER_W;
  localparam int RW       = COORD_BITS + 1 + FRAC_BITS;
  localparam int D2_W     = 2 * COORD_BITS + 1;
  localparam int DC_W     = 2 * DW + 1;
  localparam int IN_CMP_W = (DC_W > RSQ_W) ? DC_W : RSQ_W;
  localparam int MA_W     = (DW > RW) ? DW : RW;
  localparam int MB_W     = (DW > SCALE_W) ? DW : SCALE_W;
  localparam int PW       = MA_W + MB_W;

  // configuration
  logic [CENTER_W-1:0] cx_q, cy_q;
  logic [RSQ_W-1:0]    rsq_q;
  logic [SCALE_W-1:0]  scale_q;
  logic [THR_W-1:0]    thr_q;
  logic [CNT_W-1:0]    fpm_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q    <= '0;
      cy_q    <= '0;
      rsq_q   <= '0;
      scale_q <= SCALE_RST;
      thr_q   <= '0;
      fpm_q   <= FPM_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_CENTER_X:       cx_q    <= cfg_i.data[CENTER_W-1:0];
        CFG_CENTER_Y:       cy_q    <= cfg_i.data[CENTER_W-1:0];
        CFG_INNER_RSQ:      rsq_q   <= cfg_i.data[RSQ_W-1:0];
        CFG_DIST_SCALE:     scale_q <= cfg_i.data[SCALE_W-1:0];
        CFG_ACT_THRESHOLD:  thr_q   <= cfg_i.data[THR_W-1:0];
        CFG_FRAMES_PER_MIN: fpm_q   <= cfg_i.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  ctrl_t ctrl;
  logic  in_fire;
  logic  out_vld_q;
  logic  out_free;
  logic  sqrt_busy;
  res_t  res_q, res_d;

  assign in_fire  = in_i.valid && ctrl.in_ready;
  assign out_free = !out_vld_q || out_o.ready;
  assign in_i.ready = ctrl.in_ready;

  tams_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .sqrt_busy_i(sqrt_busy),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  // item latch
  logic [COORD_BITS-1:0] x_q, y_q;
  logic                  eot_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q   <= in_i.pos_x;
      y_q   <= in_i.pos_y;
      eot_q <= in_i.end_of_track;
    end
  end

  // running state
  logic [COORD_BITS-1:0] last_x_q, last_y_q;
  logic                  have_last_q;
  logic [STEP_W-1:0]     hist_q [HIST_LEN];
  logic [SW-1:0]         hist_sum_q;
  logic [FW-1:0]         fill_q;
  logic                  last_active_q;
  logic [CNT_W-1:0]      fim_q;
  logic [PATH_W-1:0]     acc_path_q;
  logic [SPEED_W-1:0]    acc_speed_q;
  logic [CNT_W-1:0]      acc_active_q, acc_shifts_q, acc_inner_q;

  // shared multiplier: squared differences, then root times scale
  logic [DW-1:0]   op_p, op_q, diff;
  logic [MA_W-1:0] mul_a;
  logic [MB_W-1:0] mul_b;
  logic [PW-1:0]   prod_d, prod_q;
  logic [RW-1:0]   root;
  logic [D2_W-1:0] d2_q;
  logic [DC_W-1:0] dc_q;

  always_comb begin
    unique case (ctrl.sq_idx)
      3'd0: begin
        op_p = DW'(x_q);
        op_q = DW'(last_x_q);
      end
      3'd1: begin
        op_p = DW'(y_q);
        op_q = DW'(last_y_q);
      end
      3'd2: begin
        op_p = DW'(x_q);
        op_q = DW'(cx_q);
      end
      3'd3: begin
        op_p = DW'(y_q);
        op_q = DW'(cy_q);
      end
      default: begin
        op_p = '0;
        op_q = '0;
      end
    endcase
  end

  assign diff   = (op_p >= op_q) ? (op_p - op_q) : (op_q - op_p);
  assign mul_a  = ctrl.scale_en ? MA_W'(root) : MA_W'(diff);
  assign mul_b  = ctrl.scale_en ? MB_W'(scale_q) : MB_W'(diff);
  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (ctrl.sq_en || ctrl.scale_en) begin
      prod_q <= prod_d;
    end
    if (in_fire) begin
      d2_q <= '0;
      dc_q <= '0;
    end else if (ctrl.sq_en) begin
      unique case (ctrl.sq_idx)
        3'd1, 3'd2: d2_q <= d2_q + D2_W'(prod_q);
        3'd3, 3'd4: dc_q <= dc_q + DC_W'(prod_q);
        default: ;
      endcase
    end
  end

  tams_sqrt #(.RW(RW)) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(ctrl.sqrt_start),
    .rad_i  ((2 * RW)'(d2_q) << (2 * FRAC_BITS)),
    .busy_o (sqrt_busy),
    .root_o (root)
  );

  // result of the item
  logic [PW-1:0]      scaled;
  logic [STEP_W-1:0]  step;
  logic [SW-1:0]      sum;
  logic               full, active, shift, inner, done;
  logic [CNT_W-1:0]   fim_n;
  logic [PATH_W-1:0]  path_n;
  logic [SPEED_W-1:0] speed_n;
  logic [CNT_W-1:0]   active_n, shifts_n, inner_n;

  always_comb begin
    scaled   = prod_q >> SCALE_W;
    step     = have_last_q ? STEP_W'(scaled) : '0;
    sum      = SW'(step) + hist_sum_q;
    full     = (fill_q == FW'(HIST_LEN));
    active   = full && (CMP_W'(sum) >= CMP_W'(thr_q));
    shift    = active ^ last_active_q;
    inner    = IN_CMP_W'(dc_q) <= IN_CMP_W'(rsq_q);
    fim_n    = fim_q + 1'b1;
    done     = eot_q || (fim_n == '0) || (fim_n >= fpm_q);
    path_n   = acc_path_q + PATH_W'(step);
    speed_n  = active ? (acc_speed_q + SPEED_W'(sum)) : acc_speed_q;
    active_n = acc_active_q + CNT_W'(active);
    shifts_n = acc_shifts_q + CNT_W'(shift);
    inner_n  = acc_inner_q + CNT_W'(inner);

    res_d                         = '0;
    res_d.step_length             = step;
    res_d.window_sum              = WSUM_W'(sum);
    res_d.window_full             = full;
    res_d.is_active               = active;
    res_d.is_shift                = shift;
    res_d.is_inner                = inner;
    res_d.minute_done             = done;
    if (done) begin
      res_d.minute_path             = path_n;
      res_d.minute_active_speed_sum = speed_n;
      res_d.minute_active_frames    = active_n;
      res_d.minute_shifts           = shifts_n;
      res_d.minute_inner_frames     = inner_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_x_q      <= '0;
      last_y_q      <= '0;
      have_last_q   <= 1'b0;
      for (int i = 0; i < HIST_LEN; i++) begin
        hist_q[i] <= '0;
      end
      hist_sum_q    <= '0;
      fill_q        <= '0;
      last_active_q <= 1'b0;
      fim_q         <= '0;
      acc_path_q    <= '0;
      acc_speed_q   <= '0;
      acc_active_q  <= '0;
      acc_shifts_q  <= '0;
      acc_inner_q   <= '0;
    end else if (ctrl.finish) begin
      if (eot_q) begin
        last_x_q      <= '0;
        last_y_q      <= '0;
        have_last_q   <= 1'b0;
        for (int i = 0; i < HIST_LEN; i++) begin
          hist_q[i] <= '0;
        end
        hist_sum_q    <= '0;
        fill_q        <= '0;
        last_active_q <= 1'b0;
        fim_q         <= '0;
        acc_path_q    <= '0;
        acc_speed_q   <= '0;
        acc_active_q  <= '0;
        acc_shifts_q  <= '0;
        acc_inner_q   <= '0;
      end else begin
        last_x_q      <= x_q;
        last_y_q      <= y_q;
        have_last_q   <= 1'b1;
        for (int i = HIST_LEN - 1; i > 0; i--) begin
          hist_q[i] <= hist_q[i-1];
        end
        hist_q[0]     <= step;
        hist_sum_q    <= sum - SW'(hist_q[HIST_LEN-1]);
        if (!full) begin
          fill_q <= fill_q + 1'b1;
        end
        last_active_q <= active;
        if (done) begin
          fim_q        <= '0;
          acc_path_q   <= '0;
          acc_speed_q  <= '0;
          acc_active_q <= '0;
          acc_shifts_q <= '0;
          acc_inner_q  <= '0;
        end else begin
          fim_q        <= fim_n;
          acc_path_q   <= path_n;
          acc_speed_q  <= speed_n;
          acc_active_q <= active_n;
          acc_shifts_q <= shifts_n;
          acc_inner_q  <= inner_n;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctrl.finish) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.finish) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid                   = out_vld_q;
  assign out_o.step_length             = res_q.step_length;
  assign out_o.window_sum              = res_q.window_sum;
  assign out_o.window_full             = res_q.window_full;
  assign out_o.is_active               = res_q.is_active;
  assign out_o.is_shift                = res_q.is_shift;
  assign out_o.is_inner                = res_q.is_inner;
  assign out_o.minute_done             = res_q.minute_done;
  assign out_o.minute_path             = res_q.minute_path;
  assign out_o.minute_active_speed_sum = res_q.minute_active_speed_sum;
  assign out_o.minute_active_frames    = res_q.minute_active_frames;
  assign out_o.minute_shifts           = res_q.minute_shifts;
  assign out_o.minute_inner_frames     = res_q.minute_inner_frames;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !ctrl.in_ready)
    else $error("item accepted while a previous item was in work");

  a_root_idle_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> !sqrt_busy)
    else $error("root unit busy at item accept");

  a_root_done_before_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.scale_en |-> !sqrt_busy)
    else $error("scaling started before the root finished");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.finish |=> out_vld_q)
    else $error("finished item not presented at the output");

endmodule
